// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- design/rvcd_pkg.sv -----
// Package with the types and constants of the run-length count decoder.
package rvcd_pkg;

    localparam int CountW          = 33;
    localparam int SmallLimit      = 252;
    localparam int HeadSpan        = 256;
    localparam int QueueDepthDflt  = 4;

    typedef enum logic [2:0] {
        PH_LIT_HEAD  = 3'd0,
        PH_LIT_EXTRA = 3'd1,
        PH_LIT_DATA  = 3'd2,
        PH_REP_HEAD  = 3'd3,
        PH_REP_EXTRA = 3'd4,
        PH_REP_BYTE  = 3'd5
    } t_phase;

    // One classified stream byte on its way from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       stream_end;
        logic       head_small;
        logic [2:0] head_extra;
    } t_item;

endpackage

// ----- design/rvcd_front.sv -----
// Input stage: takes stream requests, classifies count heads and feeds the queue.
module rvcd_front
    import rvcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_full,
    output logic       o_push,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_s_tready = !r_valid || !i_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = r_valid && !i_full;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid            = 1'b1;
            n_item.data        = i_byte;
            n_item.stream_end  = i_end;
            n_item.head_small  = ({1'b0, i_byte} < 9'(SmallLimit));
            // A long head c is followed by 256 - c extra bytes.
            n_item.head_extra  = 3'(9'(HeadSpan) - {1'b0, i_byte});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

// ----- design/rvcd_queue.sv -----
// Short first-in first-out queue of classified items between front and back.
module rvcd_queue
    import rvcd_pkg::*;
#(
    parameter int DEPTH = QueueDepthDflt
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- design/rvcd_back.sv -----
// Decode stage: runs the group state machine and holds the output register.
module rvcd_back
    import rvcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_byte,
    output logic [CountW-1:0] o_run,
    output logic              o_status,
    output logic              o_trunc
);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [2:0]        r_extra;
    logic [2:0]        n_extra;
    logic [CountW-1:0] r_acc;
    logic [CountW-1:0] n_acc;
    logic [CountW-1:0] r_remain;
    logic [CountW-1:0] n_remain;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [CountW-1:0] r_out_run;
    logic              r_out_status;
    logic              r_out_trunc;

    logic              emit;
    logic [7:0]        e_byte;
    logic [CountW-1:0] e_run;
    logic              e_status;
    logic              e_trunc;
    logic              literal;
    logic [2:0]        extra_dec;
    logic [CountW-1:0] acc_shift;
    logic [CountW-1:0] count_big;

    // An item is taken whenever the output register is free or being emptied.
    assign o_pop     = i_valid && (!r_out_valid || i_m_tready);
    assign literal   = (r_phase == PH_LIT_HEAD) || (r_phase == PH_LIT_EXTRA);
    assign extra_dec = r_extra - 3'd1;
    assign acc_shift = {r_acc[CountW-9:0], i_item.data};
    assign count_big = acc_shift + CountW'(SmallLimit);

    always_comb begin
        n_phase  = r_phase;
        n_extra  = r_extra;
        n_acc    = r_acc;
        n_remain = r_remain;
        emit     = 1'b0;
        e_byte   = i_item.data;
        e_run    = '0;
        e_status = 1'b0;
        e_trunc  = 1'b0;
        if (o_pop) begin
            if (i_item.stream_end) begin
                emit     = 1'b1;
                e_byte   = '0;
                e_status = 1'b1;
                e_trunc  = (r_phase == PH_LIT_DATA) || (r_phase == PH_REP_BYTE);
                n_phase  = PH_LIT_HEAD;
                n_extra  = '0;
                n_acc    = '0;
                n_remain = '0;
            end else begin
                case (r_phase)
                    PH_LIT_HEAD, PH_REP_HEAD: begin
                        n_acc = '0;
                        if (i_item.head_small) begin
                            n_remain = CountW'(i_item.data);
                            n_extra  = '0;
                            if (!literal) begin
                                n_phase = PH_REP_BYTE;
                            end else if (i_item.data == 8'd0) begin
                                n_phase = PH_REP_HEAD;
                            end else begin
                                n_phase = PH_LIT_DATA;
                            end
                        end else begin
                            n_extra = i_item.head_extra;
                            n_phase = literal ? PH_LIT_EXTRA : PH_REP_EXTRA;
                        end
                    end
                    PH_LIT_EXTRA, PH_REP_EXTRA: begin
                        n_acc   = acc_shift;
                        n_extra = extra_dec;
                        if (extra_dec == 3'd0) begin
                            n_remain = count_big;
                            n_acc    = '0;
                            if (!literal) begin
                                n_phase = PH_REP_BYTE;
                            end else if (count_big == '0) begin
                                n_phase = PH_REP_HEAD;
                            end else begin
                                n_phase = PH_LIT_DATA;
                            end
                        end
                    end
                    PH_LIT_DATA: begin
                        emit     = 1'b1;
                        e_run    = CountW'(1);
                        n_remain = r_remain - 1'b1;
                        if (r_remain == CountW'(1)) begin
                            n_phase = PH_REP_HEAD;
                        end
                    end
                    PH_REP_BYTE: begin
                        // A zero repeat count swallows its byte silently.
                        emit     = (r_remain != '0);
                        e_run    = r_remain;
                        n_remain = '0;
                        n_phase  = PH_LIT_HEAD;
                    end
                    default: begin
                        n_phase  = PH_LIT_HEAD;
                        n_extra  = '0;
                        n_acc    = '0;
                        n_remain = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LIT_HEAD;
            r_extra     <= '0;
            r_acc       <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_extra  <= n_extra;
            r_acc    <= n_acc;
            r_remain <= n_remain;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_out_byte   <= e_byte;
            r_out_run    <= e_run;
            r_out_status <= e_status;
            r_out_trunc  <= e_trunc;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_byte     = r_out_byte;
    assign o_run      = r_out_run;
    assign o_status   = r_out_status;
    assign o_trunc    = r_out_trunc;

endmodule

// ----- design/rle_variable_count_decoder.sv -----
// Top level of the run-length stream decoder with variable-length counts.
//
//  Channel   | Direction | tdata (low bit up)                | tuser (low bit up)
//  ----------+-----------+-----------------------------------+----------------------
//  s (input) | in        | in_byte[7:0]                      | stream_end
//  m (output)| out       | out_byte[7:0], run_length[40:8]   | is_status, truncated
//
// One byte per cycle is sustained while the output is ready; the back stage's group state
// machine updates once per byte, and its slowest path is the 33-bit count add and compare.
// An accepted request passes through the input register and the queue to the output register.
// Reset is synchronous and active low and returns the decoder to a literal count head.
// A stall on the output backs up into the queue, then the input register, then tready.
`include "assert_macros.svh"

module rle_variable_count_decoder
    import rvcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDflt
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic [0:0]  i_s_tuser,   // stream_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // out_byte, run_length, zero fill
    output logic [1:0]  o_m_tuser    // is_status, truncated
);

    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    t_item             push_item;
    t_item             pop_item;
    logic [7:0]        out_byte;
    logic [CountW-1:0] out_run;
    logic              out_status;
    logic              out_trunc;

    rvcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_end      (i_s_tuser[0]),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item)
    );

    rvcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    rvcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_byte     (out_byte),
        .o_run      (out_run),
        .o_status   (out_status),
        .o_trunc    (out_trunc)
    );

    assign o_m_tdata = {7'd0, out_run, out_byte};
    assign o_m_tuser = {out_trunc, out_status};

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, push && full && !pop, "queue overflow")
    `ASSERT_PROP(a_status_clear, i_clk, i_rst_n,
        (o_m_tvalid && out_status) |-> (out_run == '0 && out_byte == 8'd0), "bad status")
    `ASSERT_PROP(a_data_result, i_clk, i_rst_n,
        (o_m_tvalid && !out_status) |-> (out_run != '0 && !out_trunc), "bad data result")
    `ASSERT_PROP(a_pop_needs_item, i_clk, i_rst_n, pop |-> q_valid, "pop from empty queue")

endmodule
